>>> hdl/vtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_pkg
// Shared widths, constants and types of the vertex transform and lighting core.
// ----------------------------------------------------------------------------
package vtl_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned NormW   = 16;
  localparam int unsigned ClipW   = 32;
  localparam int unsigned ColW    = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRow0 = 8'd0;
  localparam logic [CfgIdxW-1:0] RegRow1 = 8'd1;
  localparam logic [CfgIdxW-1:0] RegRow2 = 8'd2;
  localparam logic [CfgIdxW-1:0] RegRow3 = 8'd3;

  localparam logic [CfgW-1:0] Row0Rst = 64'h0000_0000_0000_1000;
  localparam logic [CfgW-1:0] Row1Rst = 64'h0000_0000_1000_0000;
  localparam logic [CfgW-1:0] Row2Rst = 64'h0000_1000_0000_0000;
  localparam logic [CfgW-1:0] Row3Rst = 64'h1000_0000_0000_0000;

  // light direction, Q.12
  localparam logic signed [12:0] LightX = 13'sd1638;
  localparam logic signed [12:0] LightY = 13'sd2458;
  localparam logic signed [12:0] LightZ = 13'sd2867;

  // internal widths
  localparam int unsigned DotW  = 30;  // signed n . light
  localparam int unsigned DposW = 28;  // positive n . light
  localparam int unsigned N2W   = 32;  // |n|^2
  localparam int unsigned SqrtW = 24;  // root of |n|^2 << 16
  localparam int unsigned RadW  = 2 * SqrtW;
  localparam int unsigned QuotW = 18;  // diffuse term, Q.16
  localparam int unsigned NumW  = DposW + 13;

  localparam logic [QuotW-1:0] DiffFloor = 18'd9830;
  localparam logic [15:0] RedA = 16'd58982;
  localparam logic [15:0] RedB = 16'd6554;
  localparam logic [15:0] GrnA = 16'd36045;
  localparam logic [15:0] GrnB = 16'd3277;
  localparam logic [15:0] BluA = 16'd22938;
  localparam logic [15:0] BluB = 16'd5243;

  // stage counts
  localparam int unsigned DotLat   = 2;
  localparam int unsigned IsqrtLat = SqrtW;
  localparam int unsigned DivLat   = QuotW + 1;
  localparam int unsigned ShadeLat = 3;
  localparam int unsigned XformLat = 3;
  localparam int unsigned PipeLat  = DotLat + IsqrtLat + DivLat + ShadeLat;
  localparam int unsigned PosDly   = PipeLat - XformLat;

  typedef logic [3:0][CfgW-1:0] mat_t;

  typedef struct packed {
    logic             ok;  // non-zero normal facing the light
    logic [DposW-1:0] d;
  } light_side_t;

endpackage
`default_nettype wire

>>> hdl/vtl_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_transform
// Three-stage 4x4 matrix by (x,y,z,1) product, rounded to Q15.16, saturated.
// ----------------------------------------------------------------------------
module vtl_transform (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire vtl_pkg::mat_t                        mat_i,
  input  wire logic signed [vtl_pkg::PosW-1:0]      pos_x_i,
  input  wire logic signed [vtl_pkg::PosW-1:0]      pos_y_i,
  input  wire logic signed [vtl_pkg::PosW-1:0]      pos_z_i,
  output logic        [3:0][vtl_pkg::ClipW-1:0]     clip_o
);

  logic signed [31:0] prod_d [4][4];
  logic signed [31:0] prod_q [4][4];
  logic signed [35:0] sum_d  [4];
  logic signed [35:0] sum_q  [4];
  logic [3:0][vtl_pkg::ClipW-1:0] clip_d, clip_q;

  always_comb begin
    logic signed [15:0] e0, e1, e2, e3;
    logic signed [35:0] t, sh;
    for (int r = 0; r < 4; r++) begin
      e0 = mat_i[r][15:0];
      e1 = mat_i[r][31:16];
      e2 = mat_i[r][47:32];
      e3 = mat_i[r][63:48];
      prod_d[r][0] = e0 * pos_x_i;
      prod_d[r][1] = e1 * pos_y_i;
      prod_d[r][2] = e2 * pos_z_i;
      prod_d[r][3] = {{8{e3[15]}}, e3, 8'b0};
      sum_d[r] = {{4{prod_q[r][0][31]}}, prod_q[r][0]}
               + {{4{prod_q[r][1][31]}}, prod_q[r][1]}
               + {{4{prod_q[r][2][31]}}, prod_q[r][2]}
               + {{4{prod_q[r][3][31]}}, prod_q[r][3]};
      // round half up to Q.16: floor((s + 8) / 16)
      t  = sum_q[r] + 36'sd8;
      sh = t >>> 4;
      if ((sh[35:31] == 5'b00000) || (sh[35:31] == 5'b11111)) begin
        clip_d[r] = sh[31:0];
      end else begin
        clip_d[r] = sh[35] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      clip_q <= clip_d;
    end
  end

  assign clip_o = clip_q;

endmodule
`default_nettype wire

>>> hdl/vtl_dot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_dot
// Two-stage n . light and |n|^2 on the raw normal.
// ----------------------------------------------------------------------------
module vtl_dot (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [vtl_pkg::NormW-1:0]   norm_x_i,
  input  wire logic signed [vtl_pkg::NormW-1:0]   norm_y_i,
  input  wire logic signed [vtl_pkg::NormW-1:0]   norm_z_i,
  output logic signed      [vtl_pkg::DotW-1:0]    d_o,
  output logic             [vtl_pkg::N2W-1:0]     n2_o
);

  logic signed [28:0] pd_d [3];
  logic signed [28:0] pd_q [3];
  logic        [30:0] sq_d [3];
  logic        [30:0] sq_q [3];
  logic signed [vtl_pkg::DotW-1:0] d_q;
  logic        [vtl_pkg::N2W-1:0]  n2_q;

  always_comb begin
    logic signed [31:0] s0, s1, s2;
    pd_d[0] = norm_x_i * vtl_pkg::LightX;
    pd_d[1] = norm_y_i * vtl_pkg::LightY;
    pd_d[2] = norm_z_i * vtl_pkg::LightZ;
    s0 = norm_x_i * norm_x_i;
    s1 = norm_y_i * norm_y_i;
    s2 = norm_z_i * norm_z_i;
    sq_d[0] = s0[30:0];
    sq_d[1] = s1[30:0];
    sq_d[2] = s2[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q <= pd_d;
      sq_q <= sq_d;
      d_q  <= {pd_q[0][28], pd_q[0]} + {pd_q[1][28], pd_q[1]} + {pd_q[2][28], pd_q[2]};
      n2_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
    end
  end

  assign d_o  = d_q;
  assign n2_o = n2_q;

endmodule
`default_nettype wire

>>> hdl/vtl_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vtl_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [vtl_pkg::RadW-1:0]    rad_i,
  input  wire vtl_pkg::light_side_t        side_i,
  output logic      [vtl_pkg::SqrtW-1:0]   root_o,
  output vtl_pkg::light_side_t             side_o
);

  localparam int unsigned N    = vtl_pkg::SqrtW;
  localparam int unsigned RemW = vtl_pkg::SqrtW + 2;

  logic [vtl_pkg::RadW-1:0] rad_w  [N+1];
  logic [RemW-1:0]          rem_w  [N+1];
  logic [N-1:0]             root_w [N+1];
  vtl_pkg::light_side_t     side_w [N+1];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned J = N - 1 - k;
    logic [RemW-1:0]          cur, trial;
    logic                     ge;
    logic [vtl_pkg::RadW-1:0] rad_q;
    logic [RemW-1:0]          rem_q;
    logic [N-1:0]             root_q;
    vtl_pkg::light_side_t     side_q;

    assign cur   = {rem_w[k][RemW-3:0], rad_w[k][2*J+1 -: 2]};
    assign trial = {root_w[k], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q  <= rad_w[k];
        rem_q  <= ge ? (cur - trial) : cur;
        root_q <= {root_w[k][N-2:0], ge};
        side_q <= side_w[k];
      end
    end

    assign rad_w[k+1]  = rad_q;
    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign side_w[k+1] = side_q;
  end

  assign root_o = root_w[N];
  assign side_o = side_w[N];

endmodule
`default_nettype wire

>>> hdl/vtl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_div
// Rounded d * 4096 / r: one set-up stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtl_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [vtl_pkg::SqrtW-1:0]   root_i,
  input  wire vtl_pkg::light_side_t        side_i,
  output logic      [vtl_pkg::QuotW-1:0]   quot_o,
  output logic                             ok_o
);

  localparam int unsigned Q    = vtl_pkg::QuotW;
  localparam int unsigned NW   = vtl_pkg::NumW;
  localparam int unsigned DW   = vtl_pkg::SqrtW;
  localparam int unsigned RemW = vtl_pkg::SqrtW + 1;

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic          ok_q;

  // numerator carries half the divisor so the floor rounds half up
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {side_i.d, 12'b0} + NW'(root_i[DW-1:1]);
      den_q <= root_i;
      ok_q  <= side_i.ok;
    end
  end

  logic [NW-1:0]   num_w  [Q+1];
  logic [DW-1:0]   den_w  [Q+1];
  logic [RemW-1:0] rem_w  [Q+1];
  logic [Q-1:0]    quot_w [Q+1];
  logic            ok_w   [Q+1];

  assign num_w[0]  = num_q;
  assign den_w[0]  = den_q;
  assign rem_w[0]  = RemW'(num_q[NW-1:Q]);
  assign quot_w[0] = '0;
  assign ok_w[0]   = ok_q;

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int unsigned I = Q - 1 - k;
    logic [RemW-1:0] cur;
    logic            ge;
    logic [NW-1:0]   num_s;
    logic [DW-1:0]   den_s;
    logic [RemW-1:0] rem_s;
    logic [Q-1:0]    quot_s;
    logic            ok_s;

    assign cur = {rem_w[k][RemW-2:0], num_w[k][I]};
    assign ge  = (cur >= {1'b0, den_w[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_s  <= num_w[k];
        den_s  <= den_w[k];
        rem_s  <= ge ? (cur - {1'b0, den_w[k]}) : cur;
        quot_s <= {quot_w[k][Q-2:0], ge};
        ok_s   <= ok_w[k];
      end
    end

    assign num_w[k+1]  = num_s;
    assign den_w[k+1]  = den_s;
    assign rem_w[k+1]  = rem_s;
    assign quot_w[k+1] = quot_s;
    assign ok_w[k+1]   = ok_s;
  end

  assign quot_o = quot_w[Q];
  assign ok_o   = ok_w[Q];

endmodule
`default_nettype wire

>>> hdl/vtl_shade.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtl_shade
// Diffuse floor and tinted RGB mapping, three stages.
// ----------------------------------------------------------------------------
module vtl_shade (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic                        ok_i,
  input  wire logic [vtl_pkg::QuotW-1:0]   quot_i,
  output logic      [vtl_pkg::ColW-1:0]    color_r_o,
  output logic      [vtl_pkg::ColW-1:0]    color_g_o,
  output logic      [vtl_pkg::ColW-1:0]    color_b_o
);

  localparam int unsigned PW = vtl_pkg::QuotW + 16;
  localparam int unsigned CW = PW - 16 + 1;

  logic [vtl_pkg::QuotW-1:0] diff;
  logic [PW-1:0] prod_q [3];
  logic [CW-1:0] chan_q [3];
  logic [vtl_pkg::ColW-1:0] col_q [3];
  logic [15:0] coef_a [3];
  logic [15:0] coef_b [3];

  assign coef_a[0] = vtl_pkg::RedA;
  assign coef_a[1] = vtl_pkg::GrnA;
  assign coef_a[2] = vtl_pkg::BluA;
  assign coef_b[0] = vtl_pkg::RedB;
  assign coef_b[1] = vtl_pkg::GrnB;
  assign coef_b[2] = vtl_pkg::BluB;

  // zero or back-facing normal falls to the floor
  assign diff = (ok_i && (quot_i > vtl_pkg::DiffFloor)) ? quot_i : vtl_pkg::DiffFloor;

  always_ff @(posedge clk_i) begin
    logic [PW-1:0] rnd;
    logic [CW+8-1:0] scl;
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PW'(diff) * PW'(coef_a[c]);
        rnd = prod_q[c] + PW'(32768);
        chan_q[c] <= CW'(rnd[PW-1:16]) + CW'(coef_b[c]);
        scl = (CW+8)'(chan_q[c]) * (CW+8)'(255) + (CW+8)'(32768);
        col_q[c] <= (scl[CW+7:16] > (CW-8)'(255)) ? 8'd255 : scl[23:16];
      end
    end
  end

  assign color_r_o = col_q[0];
  assign color_g_o = col_q[1];
  assign color_b_o = col_q[2];

endmodule
`default_nettype wire

>>> hdl/vertex_transform_lighting_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_lighting_core
// Per-vertex clip transform and Lambert lighting with a tinted colour.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  word
//  s_axis    in   s_axis_tvalid/tready       pos x,y,z, normal x,y,z
//  m_axis    out  m_axis_tvalid/tready       clip x,y,z,w, colour r,g,b
//  cfg       in   cfg_we_i                   matrix rows 0..3
//
//  One vertex per cycle while no output word waits; the latency is set by the
//  24-stage square root and the 19-stage divider of the lighting path.
//  Reset empties the pipeline and loads the identity matrix.
//  A waiting output word freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module vertex_transform_lighting_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vtl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [vtl_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (16 b each)
  input  wire logic [95:0]                   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // clip_x, clip_y, clip_z, clip_w (32 b each), color_r, color_g, color_b (8 b)
  output logic [151:0]                       m_axis_tdata
);

  localparam int unsigned Lat = vtl_pkg::PipeLat;

  vtl_pkg::mat_t mat_q;
  logic [Lat-1:0] vld_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= vtl_pkg::Row0Rst;
      mat_q[1] <= vtl_pkg::Row1Rst;
      mat_q[2] <= vtl_pkg::Row2Rst;
      mat_q[3] <= vtl_pkg::Row3Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vtl_pkg::RegRow0: mat_q[0] <= cfg_data_i;
        vtl_pkg::RegRow1: mat_q[1] <= cfg_data_i;
        vtl_pkg::RegRow2: mat_q[2] <= cfg_data_i;
        vtl_pkg::RegRow3: mat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // position waits while the lighting path works
  logic [47:0] pos_dly_q [vtl_pkg::PosDly];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_dly_q[0] <= s_axis_tdata[47:0];
      for (int i = 1; i < vtl_pkg::PosDly; i++) pos_dly_q[i] <= pos_dly_q[i-1];
    end
  end

  logic [3:0][vtl_pkg::ClipW-1:0] clip;
  vtl_transform u_xform (
    .clk_i   (clk_i),
    .en_i    (en),
    .mat_i   (mat_q),
    .pos_x_i (pos_dly_q[vtl_pkg::PosDly-1][15:0]),
    .pos_y_i (pos_dly_q[vtl_pkg::PosDly-1][31:16]),
    .pos_z_i (pos_dly_q[vtl_pkg::PosDly-1][47:32]),
    .clip_o  (clip)
  );

  logic signed [vtl_pkg::DotW-1:0] dot;
  logic        [vtl_pkg::N2W-1:0]  n2;
  vtl_dot u_dot (
    .clk_i    (clk_i),
    .en_i     (en),
    .norm_x_i (s_axis_tdata[63:48]),
    .norm_y_i (s_axis_tdata[79:64]),
    .norm_z_i (s_axis_tdata[95:80]),
    .d_o      (dot),
    .n2_o     (n2)
  );

  vtl_pkg::light_side_t side_in, side_rt;
  assign side_in.ok = (n2 != '0) && !dot[vtl_pkg::DotW-1] && (dot != '0);
  assign side_in.d  = dot[vtl_pkg::DposW-1:0];

  logic [vtl_pkg::SqrtW-1:0] root;
  vtl_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({n2[vtl_pkg::RadW-17:0], 16'b0}),
    .side_i (side_in),
    .root_o (root),
    .side_o (side_rt)
  );

  logic [vtl_pkg::QuotW-1:0] quot;
  logic                      quot_ok;
  vtl_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .root_i (root),
    .side_i (side_rt),
    .quot_o (quot),
    .ok_o   (quot_ok)
  );

  logic [vtl_pkg::ColW-1:0] col_r, col_g, col_b;
  vtl_shade u_shade (
    .clk_i     (clk_i),
    .en_i      (en),
    .ok_i      (quot_ok),
    .quot_i    (quot),
    .color_r_o (col_r),
    .color_g_o (col_g),
    .color_b_o (col_b)
  );

  assign m_axis_tdata = {col_b, col_g, col_r, clip[3], clip[2], clip[1], clip[0]};

`ifndef SYNTHESIS
  // the diffuse floor puts a lower bound on every channel; red and blue are checked
  a_red_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[135:128] >= 8'd60))
    else $error("red below lighting floor");
  a_blue_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[151:144] >= 8'd34))
    else $error("blue below lighting floor");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s_axis_tvalid) |=> vld_q[0])
    else $error("accepted word not tracked");
`endif

endmodule
`default_nettype wire
